### hdl/rtki_pkg.sv
`default_nettype none

package rtki_pkg;

   // Table geometry.
   localparam int SLOTS  = 10;
   localparam int TABLES = 8;

   // Field widths of the channels.
   localparam int IDX_W   = 3;
   localparam int SCORE_W = 32;
   localparam int DUR_W   = 32;
   localparam int STAMP_W = 40;
   localparam int RANK_W  = 4;

   // The 3-bit table index can reach at most eight tables.
   localparam int TBL_USED = (TABLES < (1 << IDX_W)) ? TABLES : (1 << IDX_W);
   localparam int TBL_AW   = (TBL_USED > 1) ? $clog2(TBL_USED) : 1;

   // Entry count per table, wide enough to hold SLOTS itself.
   localparam int FILL_W = $clog2(SLOTS + 1);

   // One stored table entry.
   typedef struct packed {
      logic [SCORE_W-1:0] score;
      logic [DUR_W-1:0]   duration;
      logic [STAMP_W-1:0] stamp;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

   // Control that the sequencer hands to every cell.
   typedef struct packed {
      logic act;          // compare-and-shift cycle for a valid table
      logic valid;        // this cell's slot holds an entry of the table
      logic prev_keep;    // the cell above keeps its entry (tied high for slot 0)
      logic prev_valid;   // the cell above holds an entry that may shift down
   } cell_ctl_type;

endpackage

`default_nettype wire

### hdl/rtki_ram.sv
`default_nettype none

module rtki_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Single write port and one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

### hdl/rtki_cell.sv
`default_nettype none

module rtki_cell
   import rtki_pkg::*;
(
   input  wire logic              clock,
   input  wire logic              rd_en,
   input  wire logic [TBL_AW-1:0] rd_table,
   input  wire logic [TBL_AW-1:0] wr_table,
   input  wire cell_ctl_type      ctl,
   input  wire entry_type         new_entry,
   input  wire entry_type         prev_entry,
   output logic                   keep,
   output entry_type              cur_entry
);

   logic [ENTRY_W-1:0] rd_word;
   logic               wr_en;
   entry_type          wr_entry;

   // This slot of every table lives in one small RAM.
   rtki_ram #(
      .WIDTH(ENTRY_W),
      .DEPTH(TBL_USED)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_table),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_table),
      .rd_data (rd_word)
   );

   assign cur_entry = entry_type'(rd_word);

   // A stored entry stays ahead of a new one with an equal or lower score.
   assign keep = ctl.valid && (cur_entry.score >= new_entry.score);

   // The new item lands just below the last kept entry; cells under it take
   // their upper neighbor's entry.
   assign wr_en    = ctl.act && !keep && (ctl.prev_keep || ctl.prev_valid);
   assign wr_entry = ctl.prev_keep ? new_entry : prev_entry;

endmodule

`default_nettype wire

### hdl/ranked_top_k_table_insert.sv
`default_nettype none

// Ranked top-K insertion over several independent score tables.
// Input channel req_*: one item names a table and carries a score, a duration
// and a timestamp. It is accepted when req_valid and req_ready are both high.
// Result channel rsp_*: one item per input gives the 1-based rank of the new
// entry (0 if it did not place), the table's best score and its entry count.
// An item is handled in order: the accept edge reads the selected table from the
// RAM of every slot cell, and the next edge compares and shifts the whole row
// at once and loads the result register and rsp_valid. No new item is taken
// while the row still holds the last one.
// A new item is accepted while a result waits only in the cycle in which the
// receiver takes that result.
// A stalled receiver holds rsp_valid and the result, and req_ready stays low
// until the receiver is ready to take the waiting result.
// Reset clears every table's entry count; the slot RAMs are not cleared, since
// only slots below a table's count are ever used.
module ranked_top_k_table_insert
   import rtki_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [IDX_W-1:0]   req_table_index,
   input  wire logic [SCORE_W-1:0] req_new_score,
   input  wire logic [DUR_W-1:0]   req_duration,
   input  wire logic [STAMP_W-1:0] req_stamp,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [RANK_W-1:0]       rsp_placed_rank,
   output logic [SCORE_W-1:0]      rsp_best_score,
   output logic [RANK_W-1:0]       rsp_entry_count
);

   logic                 busy_ff, busy_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [IDX_W-1:0]     table_ff;
   entry_type            new_ff;
   logic [FILL_W-1:0]    fill_ff [TBL_USED];
   logic [RANK_W-1:0]    rank_ff, rank_in;
   logic [SCORE_W-1:0]   best_ff, best_in;
   logic [RANK_W-1:0]    count_ff, count_in;

   logic                 accept;
   logic                 table_ok;
   logic [TBL_AW-1:0]    tbl_addr;
   logic [FILL_W-1:0]    fill_cur;
   logic [FILL_W-1:0]    fill_next;
   logic [FILL_W-1:0]    rank_cnt;
   logic                 placed;
   logic [SLOTS-1:0]     keep_vec;
   logic [SLOTS-1:0]     slot_valid;
   cell_ctl_type         ctl [SLOTS];
   entry_type            cell_entry [SLOTS];
   entry_type            new_entry;

   // Handshake: one item in the row at a time, result register free for it.
   assign accept    = req_valid && req_ready;
   assign req_ready = !busy_ff && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;

   assign new_entry.score    = new_ff.score;
   assign new_entry.duration = new_ff.duration;
   assign new_entry.stamp    = new_ff.stamp;

   assign table_ok = (int'(table_ff) < TBL_USED);
   assign tbl_addr = TBL_AW'(table_ff);
   assign fill_cur = table_ok ? fill_ff[tbl_addr] : '0;

   // Per-slot occupancy and cell control.
   always_comb begin
      for (int k = 0; k < SLOTS; k++) begin
         slot_valid[k]     = (k < int'(fill_cur));
         ctl[k].act        = busy_ff && table_ok;
         ctl[k].valid      = slot_valid[k];
         ctl[k].prev_keep  = (k == 0) ? 1'b1 : keep_vec[(k == 0) ? 0 : k - 1];
         ctl[k].prev_valid = (k == 0) ? 1'b0 : slot_valid[(k == 0) ? 0 : k - 1];
      end
   end

   // Row of slot cells, each handing its entry down to the next.
   for (genvar k = 0; k < SLOTS; k++) begin : g_cell
      rtki_cell u_cell (
         .clock      (clock),
         .rd_en      (accept),
         .rd_table   (TBL_AW'(req_table_index)),
         .wr_table   (tbl_addr),
         .ctl        (ctl[k]),
         .new_entry  (new_entry),
         .prev_entry (cell_entry[(k == 0) ? 0 : k - 1]),
         .keep       (keep_vec[k]),
         .cur_entry  (cell_entry[k])
      );
   end

   // The rank counts the entries that stay ahead of the new item, plus one.
   assign rank_cnt  = FILL_W'($countones(keep_vec));
   assign placed    = !keep_vec[SLOTS-1];
   assign fill_next = (int'(fill_cur) < SLOTS) ? fill_cur + FILL_W'(1) : fill_cur;

   // Result of the compare-and-shift cycle.
   always_comb begin
      rank_in  = rank_ff;
      best_in  = best_ff;
      count_in = count_ff;
      if (busy_ff) begin
         if (!table_ok) begin
            rank_in  = '0;
            best_in  = '0;
            count_in = '0;
         end else if (placed) begin
            rank_in  = RANK_W'(rank_cnt + FILL_W'(1));
            best_in  = keep_vec[0] ? cell_entry[0].score : new_ff.score;
            count_in = RANK_W'(fill_next);
         end else begin
            rank_in  = '0;
            best_in  = cell_entry[0].score;
            count_in = RANK_W'(fill_cur);
         end
      end
   end

   // Sequencer and result valid.
   always_comb begin
      busy_in      = accept;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (busy_ff) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Entry counts per table; only a placed item changes one.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int t = 0; t < TBL_USED; t++) begin
            fill_ff[t] <= '0;
         end
      end else if (busy_ff && table_ok && placed) begin
         fill_ff[tbl_addr] <= fill_next;
      end
   end

   // Input item and result payload.
   always_ff @(posedge clock) begin
      if (accept) begin
         table_ff        <= req_table_index;
         new_ff.score    <= req_new_score;
         new_ff.duration <= req_duration;
         new_ff.stamp    <= req_stamp;
      end
      rank_ff  <= rank_in;
      best_ff  <= best_in;
      count_ff <= count_in;
   end

   assign rsp_placed_rank = rank_ff;
   assign rsp_best_score  = best_ff;
   assign rsp_entry_count = count_ff;

`ifndef ASSERT_OFF
   // The row never holds an item past its compare cycle.
   a_busy_one_cycle: assert property (@(posedge clock) disable iff (reset)
      busy_ff |=> !busy_ff)
      else $error("compare cycle lasted more than one cycle");

   // No new item enters while the row is still working.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> !req_ready)
      else $error("item accepted during compare cycle");

   // A result appears only right after a compare cycle.
   a_rsp_after_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(busy_ff))
      else $error("result without a compare cycle");

   // A table never counts more entries than it has slots.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> (int'(fill_cur) <= SLOTS))
      else $error("table entry count beyond slot count");
`endif

endmodule

`default_nettype wire
